FILE: hw/rtl/upf_pkg.sv
// Shared constants for the UTF-8 punctuation folder: byte codes, widths and defaults.
package upf_pkg;

  localparam int CFG_W = 12;
  localparam int MAX_LIMIT_DEF = 2048;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 12'd2048;

  // Lead and continuation bytes of the recognized sequences.
  localparam logic [7:0] B_E2 = 8'hE2;
  localparam logic [7:0] B_80 = 8'h80;
  localparam logic [7:0] B_C2 = 8'hC2;
  localparam logic [7:0] B_A0 = 8'hA0;
  localparam logic [7:0] B_SQ_LO = 8'h98;
  localparam logic [7:0] B_SQ_HI = 8'h9B;
  localparam logic [7:0] B_DQ_LO = 8'h9C;
  localparam logic [7:0] B_DQ_HI = 8'h9E;
  localparam logic [7:0] B_EN = 8'h93;
  localparam logic [7:0] B_EM = 8'h94;
  localparam logic [7:0] B_ELL = 8'hA6;

  // Plain ASCII codes.
  localparam logic [7:0] B_NUL = 8'h00;
  localparam logic [7:0] B_TAB = 8'h09;
  localparam logic [7:0] B_LF = 8'h0A;
  localparam logic [7:0] B_CR = 8'h0D;
  localparam logic [7:0] B_PRINT_LO = 8'h20;
  localparam logic [7:0] B_PRINT_HI = 8'h7E;

  localparam logic [6:0] C_SPACE = 7'h20;
  localparam logic [6:0] C_APOS = 7'h27;
  localparam logic [6:0] C_QUOTE = 7'h22;
  localparam logic [6:0] C_HYPHEN = 7'h2D;
  localparam logic [6:0] C_DOT = 7'h2E;
  localparam logic [6:0] C_QMARK = 7'h3F;
  localparam logic [6:0] C_TERM = 7'h00;

endpackage

FILE: hw/rtl/utf8_punctuation_folder_unit.sv
// Top level of the UTF-8 punctuation folder: input register, fold logic, result bank.
//
// Channel   Direction  Width  Contents
// s_*       in         8      tdata[7:0] in_byte (0 ends the text)
// m_*       out        8      tdata[6:0] out_char, tdata[7] zero; tlast = text_end
// cfg_*     in         12     cfg_wdata = output_limit, written when cfg_wen is high
//
// Each accepted byte is folded from the input register into a bank of up to three result
// words, and the bank drains one word per cycle while m_tready is high; bytes giving one
// word or none then flow at one per cycle. The input register takes one more byte while
// the bank still waits on m_tready. Reset is synchronous; it clears the prefix, count and
// full flag and sets the limit back to 2048.
module utf8_punctuation_folder_unit
  import upf_pkg::*;
#(
  parameter int MAX_LIMIT = MAX_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Slave side: tdata fields from bit 0: in_byte[7:0].
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  // Master side: tdata fields from bit 0: out_char[6:0], then one zero pad bit.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  // Configuration: output_limit.
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Width that holds the effective limit, and the common width for count/limit compares.
  localparam int LIM_W = $clog2(MAX_LIMIT + 1);
  localparam int CW = ((LIM_W > CFG_W) ? LIM_W : CFG_W) + 1;
  localparam int CNT_W = $clog2(MAX_LIMIT);

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_E2,
    HELD_E2_80,
    HELD_C2
  } held_t;

  // Running state of the fold while the words of one byte are generated.
  typedef struct packed {
    logic [CW-1:0]   cnt;
    logic            full;
    logic [1:0]      n;
    logic [2:0][6:0] ch;
    logic [2:0]      last;
  } work_t;

  logic [CFG_W-1:0] limit;
  held_t            held;
  logic [CNT_W-1:0] count;
  logic             full;

  logic             in_v;
  logic [7:0]       in_b;

  logic [6:0]       bank_ch [3];
  logic             bank_last [3];
  logic [1:0]       bank_rem;
  logic [1:0]       bank_rd;

  logic [CW-1:0]    lim;
  logic             adv;
  work_t            w;
  held_t            held_next;

  // The limit is taken as at least one and at most MAX_LIMIT.
  always_comb begin
    if (limit == '0) begin
      lim = CW'(1);
    end else if (CW'(limit) > CW'(MAX_LIMIT)) begin
      lim = CW'(MAX_LIMIT);
    end else begin
      lim = CW'(limit);
    end
  end

  function automatic logic is_full(work_t s, logic [CW-1:0] l);
    return s.full || ((s.cnt + CW'(1)) >= l);
  endfunction

  // One character into the buffer, unless the buffer has no room left.
  function automatic work_t emit(work_t s, logic [6:0] c, logic [CW-1:0] l);
    work_t r;
    r = s;
    if (is_full(r, l)) begin
      r.full = 1'b1;
    end else begin
      r.ch[r.n] = c;
      r.last[r.n] = 1'b0;
      r.n = r.n + 2'd1;
      r.cnt = r.cnt + CW'(1);
      if ((r.cnt + CW'(1)) >= l) r.full = 1'b1;
    end
    return r;
  endfunction

  // Fold logic: held prefix and current byte give the words and the next state.
  always_comb begin
    logic rejudge;
    w.cnt = CW'(count);
    w.full = full;
    w.n = 2'd0;
    w.ch = '0;
    w.last = '0;
    held_next = HELD_NONE;
    rejudge = 1'b1;

    case (held)
      HELD_E2: begin
        if (in_b == B_80) begin
          held_next = HELD_E2_80;
          rejudge = 1'b0;
        end else begin
          w = emit(w, C_QMARK, lim);
        end
      end
      HELD_E2_80: begin
        rejudge = 1'b0;
        if (in_b inside {[B_SQ_LO:B_SQ_HI]}) begin
          w = emit(w, C_APOS, lim);
        end else if (in_b inside {[B_DQ_LO:B_DQ_HI]}) begin
          w = emit(w, C_QUOTE, lim);
        end else if (in_b inside {B_EN, B_EM}) begin
          w = emit(w, C_HYPHEN, lim);
        end else if (in_b == B_ELL) begin
          // The ellipsis is dropped whole when fewer than three places remain.
          if (!full && ((CW'(count) + CW'(3)) < lim)) begin
            w = emit(w, C_DOT, lim);
            w = emit(w, C_DOT, lim);
            w = emit(w, C_DOT, lim);
          end
        end else begin
          w = emit(w, C_QMARK, lim);
          w = emit(w, C_QMARK, lim);
          rejudge = 1'b1;
        end
      end
      HELD_C2: begin
        if (in_b == B_A0) begin
          w = emit(w, C_SPACE, lim);
          rejudge = 1'b0;
        end else begin
          w = emit(w, C_QMARK, lim);
        end
      end
      default: begin
      end
    endcase

    if (rejudge) begin
      if (in_b == B_NUL) begin
        // The terminator always goes out and starts a new text.
        w.ch[w.n] = C_TERM;
        w.last[w.n] = 1'b1;
        w.n = w.n + 2'd1;
        w.cnt = '0;
        w.full = 1'b0;
        held_next = HELD_NONE;
      end else if (is_full(w, lim)) begin
        w.full = 1'b1;
      end else if (in_b == B_E2) begin
        held_next = HELD_E2;
      end else if (in_b == B_C2) begin
        held_next = HELD_C2;
      end else if (in_b inside {B_CR, B_TAB}) begin
        w = emit(w, C_SPACE, lim);
      end else if (in_b == B_LF || (in_b inside {[B_PRINT_LO:B_PRINT_HI]})) begin
        w = emit(w, in_b[6:0], lim);
      end else begin
        w = emit(w, C_QMARK, lim);
      end
    end
  end

  // A held byte moves into the bank once the bank is empty or gives its last word now.
  assign adv = in_v && ((bank_rem == 2'd0) || ((bank_rem == 2'd1) && m_tready));
  assign s_tready = !in_v || adv;

  assign m_tvalid = (bank_rem != 2'd0);
  assign m_tdata = {1'b0, bank_ch[bank_rd]};
  assign m_tlast = bank_last[bank_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      held <= HELD_NONE;
      count <= '0;
      full <= 1'b0;
      in_v <= 1'b0;
      bank_rem <= 2'd0;
      bank_rd <= 2'd0;
    end else begin
      if (cfg_wen) limit <= cfg_wdata;

      if (s_tvalid && s_tready) begin
        in_v <= 1'b1;
      end else if (adv) begin
        in_v <= 1'b0;
      end

      if (adv) begin
        held <= held_next;
        count <= CNT_W'(w.cnt);
        full <= w.full;
        bank_rem <= w.n;
        bank_rd <= 2'd0;
      end else if (m_tvalid && m_tready) begin
        bank_rem <= bank_rem - 2'd1;
        bank_rd <= bank_rd + 2'd1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_b <= s_tdata;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        bank_ch[i] <= w.ch[i];
        bank_last[i] <= w.last[i];
      end
    end
  end

endmodule
